FILE: rtl/hci_pkg.sv
// Shared types and constants for the HSV color interpolator.
package hci_pkg;

   localparam int CHANNEL_BITS     = 16;
   localparam int EASE_TABLE_DEPTH = 256;

   typedef logic [CHANNEL_BITS-1:0] channel_type;
   typedef logic [CHANNEL_BITS:0]   frac_type;

   typedef struct packed {
      channel_type start_red;
      channel_type start_green;
      channel_type start_blue;
      channel_type end_red;
      channel_type end_green;
      channel_type end_blue;
      frac_type    blend_progress;
   } req_type;

   typedef struct packed {
      channel_type out_red;
      channel_type out_green;
      channel_type out_blue;
   } rsp_type;

   typedef struct packed {
      channel_type hue;
      frac_type    sat;
      channel_type val;
   } hsv_type;

endpackage

FILE: rtl/hci_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module hci_div #(
   parameter int DEN_BITS  = 16,
   parameter int QUOT_BITS = 17
) (
   input  logic                 clock,
   input  logic [DEN_BITS-1:0]  num,
   input  logic [DEN_BITS-1:0]  den,
   output logic [QUOT_BITS-1:0] quot
);

   logic [DEN_BITS:0]    rem_ff [QUOT_BITS];
   logic [DEN_BITS-1:0]  den_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0] q_ff   [QUOT_BITS];

   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_stage
      logic [DEN_BITS:0]    rem_src;
      logic [DEN_BITS-1:0]  den_src;
      logic [QUOT_BITS-1:0] q_src;
      logic                 ge;
      logic [DEN_BITS:0]    rem_in;

      if (j == 0) begin : g_first
         assign rem_src = {1'b0, num};
         assign den_src = den;
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign den_src = den_ff[j-1];
         assign q_src   = q_ff[j-1];
      end

      assign ge     = rem_src >= {1'b0, den_src};
      assign rem_in = ge ? (rem_src - {1'b0, den_src}) : rem_src;

      always_ff @(posedge clock) begin
         rem_ff[j] <= {rem_in[DEN_BITS-1:0], 1'b0};
         den_ff[j] <= den_src;
         q_ff[j]   <= {q_src[QUOT_BITS-2:0], ge};
      end
   end

   assign quot = q_ff[QUOT_BITS-1];

endmodule

FILE: rtl/hci_ease.sv
// Progress saturation and, when curve_mode is set, ease-in-out sine reshaping from a cosine table.
module hci_ease #(
   parameter int EASE_TABLE_DEPTH = hci_pkg::EASE_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              curve_mode,
   input  hci_pkg::frac_type progress,
   output hci_pkg::frac_type eased
);

   localparam int C  = hci_pkg::CHANNEL_BITS;
   localparam int DB = $clog2(EASE_TABLE_DEPTH + 1);
   localparam int IW = C + 1 + DB;

   typedef logic [C:0] ease_row_type [0:EASE_TABLE_DEPTH];

   function automatic ease_row_type build_ease();
      ease_row_type      tab;
      logic [63:0]       x;
      logic [63:0]       x2;
      logic [63:0]       term;
      logic [63:0]       val;
      logic signed [63:0] sum;
      logic signed [63:0] e;
      for (int k = 0; k <= EASE_TABLE_DEPTH; k++) begin
         x    = (64'd843314857 * 64'(k) + 64'(EASE_TABLE_DEPTH / 2)) / 64'(EASE_TABLE_DEPTH);
         x2   = (x * x) >> 28;
         term = 64'd1 << 28;
         sum  = 64'sd1 <<< 28;
         for (int n = 1; n <= 30; n++) begin
            if (term != 64'd0) begin
               term = ((term * x2) >> 28) / 64'((2 * n - 1) * (2 * n));
               if (n % 2 == 1) begin
                  sum = sum - $signed(term);
               end else begin
                  sum = sum + $signed(term);
               end
            end
         end
         e = (64'sd1 <<< 28) - sum;
         if (e < 0) begin
            e = 0;
         end
         if (e > (64'sd1 <<< 29)) begin
            e = 64'sd1 <<< 29;
         end
         val = ($unsigned(e) * (64'd1 << C) + (64'd1 << 28)) >> 29;
         if (val > (64'd1 << C)) begin
            val = 64'd1 << C;
         end
         if (k > 0 && val < 64'(tab[k-1])) begin
            val = 64'(tab[k-1]);
         end
         tab[k] = val[C:0];
      end
      tab[0]                = '0;
      tab[EASE_TABLE_DEPTH] = (C+1)'(1) << C;
      return tab;
   endfunction

   localparam ease_row_type EASE_TAB = build_ease();

   hci_pkg::frac_type p_sat;
   logic [IW-1:0]     idx;
   logic [DB-1:0]     k_idx;
   logic [DB-1:0]     k_next;
   logic [C:0]        lo_in;
   logic [C:0]        hi_in;

   logic [C:0]        lo_ff;
   logic [C:0]        diff_ff;
   logic [C-1:0]      frac_ff;
   logic [C:0]        lin_ff;
   logic              mode_ff;

   logic [2*C:0]      prod;

   assign p_sat  = progress[C] ? ((C+1)'(1) << C) : progress;
   assign idx    = IW'(p_sat) * IW'(EASE_TABLE_DEPTH);
   assign k_idx  = idx[C +: DB];
   assign k_next = (k_idx == DB'(EASE_TABLE_DEPTH)) ? k_idx : (k_idx + DB'(1));
   assign lo_in  = EASE_TAB[k_idx];
   assign hi_in  = EASE_TAB[k_next];

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      diff_ff <= hi_in - lo_in;
      frac_ff <= idx[C-1:0];
      lin_ff  <= p_sat;
      mode_ff <= curve_mode;
   end

   assign prod = (2*C+1)'(diff_ff) * (2*C+1)'(frac_ff);

   always_ff @(posedge clock) begin
      eased <= mode_ff ? (lo_ff + prod[2*C:C]) : lin_ff;
   end

endmodule

FILE: rtl/hci_to_hsv.sv
// RGB to HSV conversion: extremes and hue numerator, then two pipelined dividers.
module hci_to_hsv (
   input  logic                 clock,
   input  hci_pkg::channel_type red,
   input  hci_pkg::channel_type green,
   input  hci_pkg::channel_type blue,
   output hci_pkg::hsv_type     hsv
);

   localparam int C = hci_pkg::CHANNEL_BITS;
   localparam int Q = C + 1;

   logic [C-1:0] mx;
   logic [C-1:0] mn;
   logic [C-1:0] delta;
   logic [C+2:0] d1;
   logic [C+2:0] d2;
   logic [C+2:0] d4;
   logic [C+2:0] num_in;

   logic [C+2:0] hnum_ff;
   logic [C+2:0] hden_ff;
   logic [C-1:0] delta_ff;
   logic [C-1:0] max_ff;
   logic         dz_ff;
   logic         mz_ff;

   logic [C-1:0] v_dly_ff  [Q];
   logic         dz_dly_ff [Q];
   logic         mz_dly_ff [Q];

   logic [Q-1:0] hq;
   logic [Q-1:0] sq;

   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) begin
         mx = green;
      end
      if (blue > mx) begin
         mx = blue;
      end
      if (green < mn) begin
         mn = green;
      end
      if (blue < mn) begin
         mn = blue;
      end
      delta = mx - mn;
      d1    = (C+3)'(delta);
      d2    = d1 << 1;
      d4    = d1 << 2;
      if (mx == red) begin
         num_in = (C+3)'(green) - (C+3)'(blue) + ((green < blue) ? (d2 + d4) : '0);
      end else if (mx == green) begin
         num_in = d2 + (C+3)'(blue) - (C+3)'(red);
      end else begin
         num_in = d4 + (C+3)'(red) - (C+3)'(green);
      end
   end

   always_ff @(posedge clock) begin
      hnum_ff  <= num_in;
      hden_ff  <= d2 + d4;
      delta_ff <= delta;
      max_ff   <= mx;
      dz_ff    <= (delta == '0);
      mz_ff    <= (mx == '0);
   end

   always_ff @(posedge clock) begin
      v_dly_ff[0]  <= max_ff;
      dz_dly_ff[0] <= dz_ff;
      mz_dly_ff[0] <= mz_ff;
      for (int j = 1; j < Q; j++) begin
         v_dly_ff[j]  <= v_dly_ff[j-1];
         dz_dly_ff[j] <= dz_dly_ff[j-1];
         mz_dly_ff[j] <= mz_dly_ff[j-1];
      end
   end

   hci_div #(.DEN_BITS(C + 3), .QUOT_BITS(Q)) u_hue_div (
      .clock (clock),
      .num   (hnum_ff),
      .den   (hden_ff),
      .quot  (hq)
   );

   hci_div #(.DEN_BITS(C), .QUOT_BITS(Q)) u_sat_div (
      .clock (clock),
      .num   (delta_ff),
      .den   (max_ff),
      .quot  (sq)
   );

   assign hsv.hue = dz_dly_ff[Q-1] ? '0 : hq[C-1:0];
   assign hsv.sat = mz_dly_ff[Q-1] ? '0 : sq;
   assign hsv.val = v_dly_ff[Q-1];

endmodule

FILE: rtl/hci_to_rgb.sv
// HSV to RGB conversion in three register stages.
module hci_to_rgb (
   input  logic             clock,
   input  hci_pkg::hsv_type hsv,
   output hci_pkg::rsp_type rgb
);

   localparam int C = hci_pkg::CHANNEL_BITS;

   typedef enum logic [2:0] {
      SEC_RED_YELLOW,
      SEC_YELLOW_GREEN,
      SEC_GREEN_CYAN,
      SEC_CYAN_BLUE,
      SEC_BLUE_MAGENTA,
      SEC_MAGENTA_RED
   } sector_type;

   logic [2*C:0] vs_prod;
   logic [C+2:0] h6;
   logic [C:0]   xf_in;

   logic [C-1:0] c_ff;
   logic [C-1:0] v_ff;
   logic [2:0]   sec_ff;
   logic [C:0]   xf_ff;

   logic [2*C:0] x_prod;

   logic [C-1:0] x2_ff;
   logic [C-1:0] c2_ff;
   logic [C-1:0] m2_ff;
   logic [2:0]   sec2_ff;

   logic [C-1:0] rr;
   logic [C-1:0] gg;
   logic [C-1:0] bb;

   function automatic logic [C-1:0] sat_add(input logic [C-1:0] a, input logic [C-1:0] b);
      logic [C:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[C] ? {C{1'b1}} : s[C-1:0];
   endfunction

   assign vs_prod = (2*C+1)'(hsv.val) * (2*C+1)'(hsv.sat);
   assign h6      = (C+3)'(hsv.hue) * (C+3)'(6);
   assign xf_in   = h6[C] ? (((C+1)'(1) << C) - (C+1)'(h6[C-1:0])) : (C+1)'(h6[C-1:0]);

   always_ff @(posedge clock) begin
      c_ff   <= vs_prod[2*C-1:C];
      v_ff   <= hsv.val;
      sec_ff <= h6[C+2:C];
      xf_ff  <= xf_in;
   end

   assign x_prod = (2*C+1)'(c_ff) * (2*C+1)'(xf_ff);

   always_ff @(posedge clock) begin
      x2_ff   <= x_prod[2*C-1:C];
      c2_ff   <= c_ff;
      m2_ff   <= v_ff - c_ff;
      sec2_ff <= sec_ff;
   end

   always_comb begin
      case (sector_type'(sec2_ff))
         SEC_RED_YELLOW: begin
            rr = c2_ff; gg = x2_ff; bb = '0;
         end
         SEC_YELLOW_GREEN: begin
            rr = x2_ff; gg = c2_ff; bb = '0;
         end
         SEC_GREEN_CYAN: begin
            rr = '0; gg = c2_ff; bb = x2_ff;
         end
         SEC_CYAN_BLUE: begin
            rr = '0; gg = x2_ff; bb = c2_ff;
         end
         SEC_BLUE_MAGENTA: begin
            rr = x2_ff; gg = '0; bb = c2_ff;
         end
         default: begin
            rr = c2_ff; gg = '0; bb = x2_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rgb.out_red   <= sat_add(rr, m2_ff);
      rgb.out_green <= sat_add(gg, m2_ff);
      rgb.out_blue  <= sat_add(bb, m2_ff);
   end

endmodule

FILE: rtl/hsv_color_interpolator_unit.sv
// Top level of the HSV color interpolator: input stage, blend stages and result strobe.
//
//   channel   ports                               direction   handshake
//   request   start, busy, req_data               in          start && !busy
//   result    rsp_strobe, rsp_data                out         one-cycle strobe
//   control   csr_write_enable, csr_write_data    in          write enable
//
// One item per cycle; each result follows its item through the input register, the
// one-bit-per-stage hue and saturation dividers, the blend stages and the RGB stages.
// Synchronous reset clears the valid pipeline and curve_mode; busy stays low.
// Results cannot be held off, so the pipeline always advances.
module hsv_color_interpolator_unit #(
   parameter int EASE_TABLE_DEPTH = hci_pkg::EASE_TABLE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hci_pkg::req_type req_data,
   output logic             rsp_strobe,
   output hci_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic             csr_write_data
);

   localparam int C   = hci_pkg::CHANNEL_BITS;
   localparam int Q   = C + 1;
   localparam int LAT = Q + 8;

   logic              curve_mode_ff;
   logic              valid_ff [LAT];
   hci_pkg::req_type  req_ff;

   hci_pkg::hsv_type  hsv_a;
   hci_pkg::hsv_type  hsv_b;
   hci_pkg::frac_type eased;
   hci_pkg::frac_type p_dly_ff [Q-1];

   logic [C-1:0]      ha_in;
   logic [C-1:0]      hb_in;
   logic signed [C+1:0] d_raw;
   logic signed [C+1:0] d_in;

   logic [C-1:0]      ha_ff;
   logic              dneg_ff;
   logic [C-1:0]      dmag_ff;
   logic [C:0]        sa_ff;
   logic              sneg_ff;
   logic [C:0]        smag_ff;
   logic [C-1:0]      va_ff;
   logic              vneg_ff;
   logic [C-1:0]      vmag_ff;
   logic [C:0]        p_ff;

   logic [2*C:0]      hp_in;
   logic [2*C+1:0]    sp_in;
   logic [2*C:0]      vp_in;

   logic [C-1:0]      ha2_ff;
   logic              dneg2_ff;
   logic [C-1:0]      hp_ff;
   logic [C:0]        sa2_ff;
   logic              sneg2_ff;
   logic [C:0]        sp_ff;
   logic [C-1:0]      va2_ff;
   logic              vneg2_ff;
   logic [C-1:0]      vp_ff;

   hci_pkg::hsv_type  mix_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         curve_mode_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LAT; j++) begin
            valid_ff[j] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= start && !busy;
         for (int j = 1; j < LAT; j++) begin
            valid_ff[j] <= valid_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   hci_to_hsv u_hsv_a (
      .clock (clock),
      .red   (req_ff.start_red),
      .green (req_ff.start_green),
      .blue  (req_ff.start_blue),
      .hsv   (hsv_a)
   );

   hci_to_hsv u_hsv_b (
      .clock (clock),
      .red   (req_ff.end_red),
      .green (req_ff.end_green),
      .blue  (req_ff.end_blue),
      .hsv   (hsv_b)
   );

   hci_ease #(.EASE_TABLE_DEPTH(EASE_TABLE_DEPTH)) u_ease (
      .clock      (clock),
      .curve_mode (curve_mode_ff),
      .progress   (req_ff.blend_progress),
      .eased      (eased)
   );

   // hold progress until the dividers finish
   always_ff @(posedge clock) begin
      p_dly_ff[0] <= eased;
      for (int j = 1; j < Q - 1; j++) begin
         p_dly_ff[j] <= p_dly_ff[j-1];
      end
   end

   always_comb begin
      ha_in = (hsv_a.sat == '0) ? hsv_b.hue : hsv_a.hue;
      hb_in = (hsv_b.sat == '0) ? ha_in : hsv_b.hue;
      d_raw = $signed((C+2)'(hb_in)) - $signed((C+2)'(ha_in));
      if (d_raw > $signed((C+2)'(1) << (C - 1))) begin
         d_in = d_raw - $signed((C+2)'(1) << C);
      end else if (d_raw < -$signed((C+2)'(1) << (C - 1))) begin
         d_in = d_raw + $signed((C+2)'(1) << C);
      end else begin
         d_in = d_raw;
      end
   end

   always_ff @(posedge clock) begin
      ha_ff   <= ha_in;
      dneg_ff <= d_in[C+1];
      dmag_ff <= d_in[C+1] ? C'(-d_in) : C'(d_in);
      sa_ff   <= hsv_a.sat;
      sneg_ff <= hsv_b.sat < hsv_a.sat;
      smag_ff <= (hsv_b.sat < hsv_a.sat) ? (hsv_a.sat - hsv_b.sat) : (hsv_b.sat - hsv_a.sat);
      va_ff   <= hsv_a.val;
      vneg_ff <= hsv_b.val < hsv_a.val;
      vmag_ff <= (hsv_b.val < hsv_a.val) ? (hsv_a.val - hsv_b.val) : (hsv_b.val - hsv_a.val);
      p_ff    <= p_dly_ff[Q-2];
   end

   assign hp_in = (2*C+1)'(dmag_ff) * (2*C+1)'(p_ff);
   assign sp_in = (2*C+2)'(smag_ff) * (2*C+2)'(p_ff);
   assign vp_in = (2*C+1)'(vmag_ff) * (2*C+1)'(p_ff);

   always_ff @(posedge clock) begin
      ha2_ff   <= ha_ff;
      dneg2_ff <= dneg_ff;
      hp_ff    <= hp_in[2*C-1:C];
      sa2_ff   <= sa_ff;
      sneg2_ff <= sneg_ff;
      sp_ff    <= sp_in[2*C:C];
      va2_ff   <= va_ff;
      vneg2_ff <= vneg_ff;
      vp_ff    <= vp_in[2*C-1:C];
   end

   always_ff @(posedge clock) begin
      mix_ff.hue <= dneg2_ff ? (ha2_ff - hp_ff) : (ha2_ff + hp_ff);
      mix_ff.sat <= sneg2_ff ? (sa2_ff - sp_ff) : (sa2_ff + sp_ff);
      mix_ff.val <= vneg2_ff ? (va2_ff - vp_ff) : (va2_ff + vp_ff);
   end

   hci_to_rgb u_to_rgb (
      .clock (clock),
      .hsv   (mix_ff),
      .rgb   (rsp_data)
   );

   assign rsp_strobe = valid_ff[LAT-1];

endmodule
